FILE: src/mcf_pkg.sv
// shared constants and types of the max-cost flow solver
`timescale 1ns / 1ps
`default_nettype none
package mcf_pkg;
	localparam int MAX_NODES = 128;
	localparam int MAX_EDGES = 4096;
	localparam int NODE_W    = $clog2(MAX_NODES);
	localparam int EDGE_W    = $clog2(MAX_EDGES);
	localparam int LINK_W    = EDGE_W + 1;
	localparam int CAP_W     = 16;
	localparam int COST_W    = 32;
	localparam int DIST_W    = 48;
	localparam int FLOW_W    = 24;
	localparam int PUSH_CAP  = 10000;
	localparam int AMT_W     = $clog2(PUSH_CAP + 1);
	localparam int CNT_W     = $clog2(MAX_NODES + 2);
	localparam int STEP_W    = $clog2(MAX_NODES + 1);
	localparam int CFG_IDX_W = 1;

	localparam logic [LINK_W-1:0] NIL_LINK = {LINK_W{1'b1}};
	localparam logic [NODE_W-1:0] SINK_RESET = NODE_W'(MAX_NODES - 1);

	localparam logic [1:0] FUNC_CLEAR = 2'd0;
	localparam logic [1:0] FUNC_ADD   = 2'd1;
	localparam logic [1:0] FUNC_RUN   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SINK   = 1'b1;

	typedef struct packed {
		logic [NODE_W-1:0] target;
		logic [NODE_W-1:0] origin;
		logic [COST_W-1:0] weight;
		logic [LINK_W-1:0] link;
	} edge_info_t;
endpackage
`default_nettype wire

FILE: src/mcf_if.sv
// channel interfaces of the max-cost flow solver
`timescale 1ns / 1ps
`default_nettype none
interface mcf_item_if;
	import mcf_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        func;
	logic [NODE_W-1:0] from_node;
	logic [NODE_W-1:0] to_node;
	logic [CAP_W-1:0]  capacity;
	logic signed [COST_W-1:0] edge_cost;
	modport source (output valid, func, from_node, to_node, capacity, edge_cost, input ready);
	modport sink (input valid, func, from_node, to_node, capacity, edge_cost, output ready);
endinterface

interface mcf_result_if;
	import mcf_pkg::*;
	logic              valid;
	logic              ready;
	logic [FLOW_W-1:0] total_flow;
	logic signed [DIST_W-1:0] total_cost;
	logic              status;
	modport source (output valid, total_flow, total_cost, status, input ready);
	modport sink (input valid, total_flow, total_cost, status, output ready);
endinterface

interface mcf_cfg_if;
	import mcf_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [NODE_W-1:0]    data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: src/max_cost_flow_solver.sv
// max-cost flow solver: edge store, spfa search and augmentation sequencer
//
// channel  dir  handshake      word
// item     in   valid/ready    func, from_node, to_node, capacity, edge_cost
// result   out  valid/ready    total_flow, total_cost, status
// cfg      in   valid/ready    index, data (source_node, sink_node)
//
// clear acts when the item is accepted; add edge writes its two entries in S_ADD1 and S_ADD2 (one edge ram write port)
// a run repeats, per augmentation, the search (queue pops and edge scans), the walk back
// from the sink along the predecessor edges, and the push of the amount along that path
// one item at a time: item.ready is high only while the sequencer is idle
// a finished result sits in an output register, the next item is taken meanwhile
// arst_n clears control state, list heads and the sticky overflow flag
`timescale 1ns / 1ps
`default_nettype none
module max_cost_flow_solver
	import mcf_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	mcf_item_if.sink      item,
	mcf_result_if.source  result,
	mcf_cfg_if.sink       cfg
);
	typedef enum logic [4:0] {
		S_IDLE, S_ADD1, S_ADD2, S_INIT, S_POP, S_POP1, S_POP2, S_EDGE, S_E1, S_E2,
		S_SEND, S_CHK, S_W0, S_W1, S_W2, S_A0, S_A1, S_A2, S_A3, S_T1, S_T2, S_DONE
	} state_t;

	state_t state_q;
	logic [NODE_W-1:0] src_q, snk_q;
	logic [LINK_W-1:0] count_q, e_q, link_q;
	logic              ovf_q;
	logic [NODE_W-1:0] fa_q, fb_q, u_q, v_q, node_q;
	logic [CAP_W-1:0]  cap_q;
	logic [COST_W-1:0] cost_in_q;
	logic signed [DIST_W-1:0] du_q, nd_q, dsnk_q, csum_q;
	logic [NODE_W-1:0] qh_q;
	logic [NODE_W:0]   qn_q;
	logic [FLOW_W-1:0] flow_q;
	logic [AMT_W-1:0]  amt_q;
	logic [STEP_W-1:0] steps_q;
	logic signed [DIST_W+AMT_W:0] prod_q;
	logic [MAX_NODES-1:0] head_vld_q, reached_q, inq_q;
	logic              res_valid_q, res_status_q;
	logic [FLOW_W-1:0] res_flow_q;
	logic signed [DIST_W-1:0] res_cost_q;

	// ram ports
	logic head_we, info_we, res_we, dist_we, cnt_we, pred_we, queue_we;
	logic [NODE_W-1:0] head_waddr, head_raddr, dist_waddr, dist_raddr;
	logic [NODE_W-1:0] cnt_waddr, cnt_raddr, pred_waddr, pred_raddr;
	logic [NODE_W-1:0] queue_waddr, queue_raddr, queue_wdata, queue_rdata;
	logic [EDGE_W-1:0] head_wdata, head_rdata, pred_wdata, pred_rdata;
	logic [EDGE_W-1:0] info_waddr, info_raddr, res_waddr, res_raddr;
	edge_info_t        info_wdata, info_rdata;
	logic [CAP_W-1:0]  res_wdata, res_rdata;
	logic [DIST_W-1:0] dist_wdata, dist_rdata;
	logic [CNT_W-1:0]  cnt_wdata, cnt_rdata;

	logic [EDGE_W-1:0] e_addr, e_twin, cnt_e1;
	logic [NODE_W-1:0] qtail;
	logic [COST_W-1:0] rev_cost;
	logic signed [DIST_W:0] sum49;
	logic signed [DIST_W-1:0] nd_sat;
	logic [CNT_W-1:0]  cnt_new;
	logic              relax, item_acc;
	logic signed [DIST_W+AMT_W+1:0] csum_wide;
	logic signed [DIST_W-1:0] csum_sat;
	logic [FLOW_W:0]   flow_wide;

	assign e_addr   = e_q[EDGE_W-1:0];
	assign e_twin   = {e_q[EDGE_W-1:1], ~e_q[0]};
	assign cnt_e1   = EDGE_W'(count_q) | EDGE_W'(1);
	assign qtail    = qh_q + qn_q[NODE_W-1:0];
	assign rev_cost = (cost_in_q == {1'b1, {(COST_W-1){1'b0}}}) ?
		{1'b0, {(COST_W-1){1'b1}}} : (~cost_in_q + COST_W'(1));
	assign item_acc = item.valid && item.ready;

	// saturating distance add
	assign sum49  = $signed({du_q[DIST_W-1], du_q}) +
		$signed({{(DIST_W+1-COST_W){info_rdata.weight[COST_W-1]}}, info_rdata.weight});
	assign nd_sat = (sum49[DIST_W] != sum49[DIST_W-1]) ?
		(sum49[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}}) :
		sum49[DIST_W-1:0];

	assign relax   = !reached_q[v_q] || (nd_q > $signed(dist_rdata));
	assign cnt_new = (reached_q[v_q] ? cnt_rdata : CNT_W'(0)) + CNT_W'(1);

	assign csum_wide = $signed({{(AMT_W+2){csum_q[DIST_W-1]}}, csum_q}) +
		$signed({prod_q[DIST_W+AMT_W], prod_q});
	assign csum_sat  = (csum_wide > $signed({{(AMT_W+2){1'b0}}, 1'b0, {(DIST_W-1){1'b1}}})) ?
		{1'b0, {(DIST_W-1){1'b1}}} :
		(csum_wide < $signed({{(AMT_W+2){1'b1}}, 1'b1, {(DIST_W-1){1'b0}}})) ?
		{1'b1, {(DIST_W-1){1'b0}}} : csum_wide[DIST_W-1:0];
	assign flow_wide = {1'b0, flow_q} + (FLOW_W+1)'(amt_q);

	assign item.ready = (state_q == S_IDLE);
	assign cfg.ready  = 1'b1;
	assign result.valid      = res_valid_q;
	assign result.total_flow = res_flow_q;
	assign result.total_cost = res_cost_q;
	assign result.status     = res_status_q;

	always_comb begin
		head_we = 1'b0; info_we = 1'b0; res_we = 1'b0; dist_we = 1'b0;
		cnt_we = 1'b0; pred_we = 1'b0; queue_we = 1'b0;
		head_waddr = fa_q; head_wdata = EDGE_W'(count_q);
		head_raddr = u_q;
		info_waddr = EDGE_W'(count_q);
		info_wdata = '{target: fb_q, origin: fa_q, weight: cost_in_q, link: NIL_LINK};
		info_raddr = e_addr;
		res_waddr = EDGE_W'(count_q); res_wdata = cap_q; res_raddr = e_addr;
		dist_waddr = v_q; dist_wdata = nd_q; dist_raddr = v_q;
		cnt_waddr = v_q; cnt_wdata = cnt_new; cnt_raddr = v_q;
		pred_waddr = v_q; pred_wdata = e_addr; pred_raddr = node_q;
		queue_waddr = qtail; queue_wdata = v_q; queue_raddr = qh_q;
		case (state_q)
			S_IDLE: begin
				head_raddr = item.from_node;
			end
			S_ADD1: begin
				head_we = 1'b1;
				head_raddr = fb_q;
				info_we = 1'b1;
				info_wdata.link = head_vld_q[fa_q] ? {1'b0, head_rdata} : NIL_LINK;
				res_we = 1'b1;
			end
			S_ADD2: begin
				head_we = 1'b1; head_waddr = fb_q; head_wdata = cnt_e1;
				info_we = 1'b1; info_waddr = cnt_e1;
				info_wdata.target = fa_q;
				info_wdata.origin = fb_q;
				info_wdata.weight = rev_cost;
				// a self loop links the twin to the edge written just before
				info_wdata.link = (fa_q == fb_q) ? {1'b0, EDGE_W'(count_q)} :
					(head_vld_q[fb_q] ? {1'b0, head_rdata} : NIL_LINK);
				res_we = 1'b1; res_waddr = cnt_e1; res_wdata = '0;
			end
			S_INIT: begin
				dist_we = 1'b1; dist_waddr = src_q; dist_wdata = '0;
				cnt_we = 1'b1; cnt_waddr = src_q; cnt_wdata = '0;
				queue_we = 1'b1; queue_waddr = '0; queue_wdata = src_q;
			end
			S_POP1: begin
				dist_raddr = queue_rdata;
				head_raddr = queue_rdata;
			end
			S_E1: begin
				dist_raddr = info_rdata.target;
				cnt_raddr = info_rdata.target;
			end
			S_E2: begin
				if (relax) begin
					dist_we = 1'b1;
					cnt_we = 1'b1;
					pred_we = 1'b1;
					queue_we = !inq_q[v_q];
				end
			end
			S_SEND: begin
				dist_raddr = snk_q;
			end
			S_W1, S_A1: begin
				info_raddr = pred_rdata;
				res_raddr = pred_rdata;
			end
			S_A2: begin
				res_we = 1'b1; res_waddr = e_addr;
				res_wdata = res_rdata - CAP_W'(amt_q);
				res_raddr = e_twin;
			end
			S_A3: begin
				res_we = 1'b1; res_waddr = e_twin;
				res_wdata = res_rdata + CAP_W'(amt_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			src_q <= '0;
			snk_q <= SINK_RESET;
			count_q <= '0;
			ovf_q <= 1'b0;
			head_vld_q <= '0;
			reached_q <= '0;
			inq_q <= '0;
			qh_q <= '0;
			qn_q <= '0;
			flow_q <= '0;
			csum_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					CFG_SOURCE: src_q <= cfg.data;
					CFG_SINK: snk_q <= cfg.data;
					default: begin
					end
				endcase
			end
			if (result.ready && state_q != S_DONE) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					fa_q <= item.from_node;
					fb_q <= item.to_node;
					cap_q <= item.capacity;
					cost_in_q <= item.edge_cost;
					if (item_acc) begin
						case (item.func)
							FUNC_CLEAR: begin
								head_vld_q <= '0;
								count_q <= '0;
								ovf_q <= 1'b0;
							end
							FUNC_ADD: begin
								// node fields are as wide as the node range
								if ({1'b0, count_q} + (LINK_W+1)'(2) > (LINK_W+1)'(MAX_EDGES)) begin
									ovf_q <= 1'b1;
								end else begin
									state_q <= S_ADD1;
								end
							end
							FUNC_RUN: begin
								flow_q <= '0;
								csum_q <= '0;
								state_q <= (src_q == snk_q) ? S_DONE : S_INIT;
							end
							default: begin
							end
						endcase
					end
				end
				S_ADD1: begin
					head_vld_q[fa_q] <= 1'b1;
					state_q <= S_ADD2;
				end
				S_ADD2: begin
					head_vld_q[fb_q] <= 1'b1;
					count_q <= count_q + LINK_W'(2);
					state_q <= S_IDLE;
				end
				S_INIT: begin
					reached_q <= MAX_NODES'(1) << src_q;
					inq_q <= MAX_NODES'(1) << src_q;
					qh_q <= '0;
					qn_q <= (NODE_W+1)'(1);
					state_q <= S_POP;
				end
				S_POP: begin
					state_q <= (qn_q == '0) ? S_SEND : S_POP1;
				end
				S_POP1: begin
					u_q <= queue_rdata;
					qh_q <= qh_q + NODE_W'(1);
					qn_q <= qn_q - (NODE_W+1)'(1);
					inq_q[queue_rdata] <= 1'b0;
					state_q <= S_POP2;
				end
				S_POP2: begin
					du_q <= dist_rdata;
					e_q <= head_vld_q[u_q] ? {1'b0, head_rdata} : NIL_LINK;
					state_q <= S_EDGE;
				end
				S_EDGE: begin
					state_q <= (e_q < count_q) ? S_E1 : S_POP;
				end
				S_E1: begin
					v_q <= info_rdata.target;
					link_q <= info_rdata.link;
					nd_q <= nd_sat;
					if (res_rdata == '0) begin
						e_q <= info_rdata.link;
						state_q <= S_EDGE;
					end else begin
						state_q <= S_E2;
					end
				end
				S_E2: begin
					e_q <= link_q;
					// positive cycle: stop with the totals so far
					state_q <= (relax && cnt_new > CNT_W'(MAX_NODES)) ? S_DONE : S_EDGE;
					if (relax) begin
						reached_q[v_q] <= 1'b1;
						if (!inq_q[v_q]) begin
							inq_q[v_q] <= 1'b1;
							qn_q <= qn_q + (NODE_W+1)'(1);
						end
					end
				end
				S_SEND: begin
					state_q <= reached_q[snk_q] ? S_CHK : S_DONE;
				end
				S_CHK: begin
					dsnk_q <= dist_rdata;
					amt_q <= AMT_W'(PUSH_CAP);
					node_q <= snk_q;
					steps_q <= '0;
					state_q <= dist_rdata[DIST_W-1] ? S_DONE : S_W0;
				end
				S_W0: begin
					if (node_q == src_q) begin
						node_q <= snk_q;
						state_q <= (amt_q == '0) ? S_DONE : S_A0;
					end else begin
						state_q <= S_W1;
					end
				end
				S_W1: begin
					e_q <= {1'b0, pred_rdata};
					steps_q <= steps_q + STEP_W'(1);
					if (steps_q >= STEP_W'(MAX_NODES) || {1'b0, pred_rdata} >= count_q) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_W2;
					end
				end
				S_W2: begin
					if (res_rdata < CAP_W'(amt_q)) begin
						amt_q <= res_rdata[AMT_W-1:0];
					end
					node_q <= info_rdata.origin;
					state_q <= S_W0;
				end
				S_A0: begin
					state_q <= (node_q == src_q) ? S_T1 : S_A1;
				end
				S_A1: begin
					e_q <= {1'b0, pred_rdata};
					state_q <= S_A2;
				end
				S_A2: begin
					node_q <= info_rdata.origin;
					state_q <= ({1'b0, e_twin} < count_q) ? S_A3 : S_A0;
				end
				S_A3: begin
					state_q <= S_A0;
				end
				S_T1: begin
					prod_q <= dsnk_q * $signed({1'b0, amt_q});
					flow_q <= flow_wide[FLOW_W] ? {FLOW_W{1'b1}} : flow_wide[FLOW_W-1:0];
					state_q <= S_T2;
				end
				S_T2: begin
					csum_q <= csum_sat;
					state_q <= S_INIT;
				end
				S_DONE: begin
					if (!res_valid_q || result.ready) begin
						res_valid_q <= 1'b1;
						res_flow_q <= flow_q;
						res_cost_q <= csum_q;
						res_status_q <= ovf_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	mcf_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_NODES)) u_head (
		.clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
		.raddr(head_raddr), .rdata(head_rdata)
	);
	mcf_ram #(.WIDTH($bits(edge_info_t)), .DEPTH(MAX_EDGES)) u_info (
		.clk(clk), .we(info_we), .waddr(info_waddr), .wdata(info_wdata),
		.raddr(info_raddr), .rdata(info_rdata)
	);
	mcf_ram #(.WIDTH(CAP_W), .DEPTH(MAX_EDGES)) u_res (
		.clk(clk), .we(res_we), .waddr(res_waddr), .wdata(res_wdata),
		.raddr(res_raddr), .rdata(res_rdata)
	);
	mcf_ram #(.WIDTH(DIST_W), .DEPTH(MAX_NODES)) u_dist (
		.clk(clk), .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
		.raddr(dist_raddr), .rdata(dist_rdata)
	);
	mcf_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES)) u_cnt (
		.clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.raddr(cnt_raddr), .rdata(cnt_rdata)
	);
	mcf_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_NODES)) u_pred (
		.clk(clk), .we(pred_we), .waddr(pred_waddr), .wdata(pred_wdata),
		.raddr(pred_raddr), .rdata(pred_rdata)
	);
	mcf_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue (
		.clk(clk), .we(queue_we), .waddr(queue_waddr), .wdata(queue_wdata),
		.raddr(queue_raddr), .rdata(queue_rdata)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LINK_W'(MAX_EDGES))
		else $error("edge count beyond store");
	a_count_even: assert property (@(posedge clk) disable iff (!arst_n)
		!count_q[0])
		else $error("edge count lost its twin pairing");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc && item.func == FUNC_CLEAR |=> count_q == '0 && !ovf_q)
		else $error("clear did not empty the graph");
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qn_q <= (NODE_W+1)'(MAX_NODES))
		else $error("work queue overfilled");
endmodule
`default_nettype wire

FILE: src/mcf_ram.sv
// generic one-write one-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module mcf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: test/tb_max_cost_flow_solver.sv
// self-checking testbench of the max-cost flow solver, with its own flow predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_max_cost_flow_solver;
	import mcf_pkg::*;

	localparam int unsigned NO_EDGE   = 32'hFFFF_FFFF;
	localparam longint      DIST_MAX  = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint      DIST_MIN  = -DIST_MAX - 1;
	localparam int unsigned FLOW_SAT  = 32'h00FF_FFFF;
	localparam int          IDLE_LIMIT = 500000;
	localparam int          ITEM_GOAL  = 2250;
	localparam int          QUIET_FROM = 2100;
	localparam logic [1:0]  FUNC_BAD   = 2'd3;

	typedef struct packed {
		logic [FLOW_W-1:0]        flow;
		logic signed [DIST_W-1:0] cost;
		logic                     status;
	} totals_t;

	typedef struct packed {
		logic [1:0]               func;
		logic [NODE_W-1:0]        from_node;
		logic [NODE_W-1:0]        to_node;
		logic [CAP_W-1:0]         capacity;
		logic signed [COST_W-1:0] edge_cost;
		logic                     typed;
		totals_t                  want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #5 clk = ~clk;

	mcf_item_if   item_ch();
	mcf_result_if res_ch();
	mcf_cfg_if    cfg_ch();

	max_cost_flow_solver u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// predictor state
	int unsigned g_to[MAX_EDGES], g_from[MAX_EDGES], g_res[MAX_EDGES], g_next[MAX_EDGES];
	int          g_wt[MAX_EDGES];
	int unsigned g_head[MAX_NODES];
	int unsigned g_count;
	bit          g_full;
	int unsigned src_sel, snk_sel;
	longint      s_dist[MAX_NODES];
	bit          s_seen[MAX_NODES];
	int unsigned s_pred[MAX_NODES];

	totals_t pending_totals[$];
	int      mismatches = 0;
	int      idle_cycles = 0;
	bit      quiet;
	int      items_sent;

	function automatic longint sat48(longint v);
		if (v > DIST_MAX) return DIST_MAX;
		if (v < DIST_MIN) return DIST_MIN;
		return v;
	endfunction

	function automatic void graph_clear();
		for (int i = 0; i < MAX_NODES; i++) g_head[i] = NO_EDGE;
		g_count = 0;
		g_full = 1'b0;
	endfunction

	function automatic void graph_put(int unsigned a, int unsigned b, int unsigned cap, int w);
		g_from[g_count] = a;
		g_to[g_count] = b;
		g_res[g_count] = cap;
		g_wt[g_count] = w;
		g_next[g_count] = g_head[a];
		g_head[a] = g_count;
		g_count++;
	endfunction

	function automatic void graph_add(int unsigned a, int unsigned b, int unsigned cap, int w);
		longint rw;
		rw = -longint'(w);
		if (rw > 64'sh7FFF_FFFF) rw = 64'sh7FFF_FFFF;
		if (g_count + 2 > MAX_EDGES) begin
			g_full = 1'b1;
			return;
		end
		graph_put(a, b, cap, w);
		graph_put(b, a, 0, int'(rw));
	endfunction

	// queue-based longest path search; 0 when a node relaxes too often
	function automatic bit longest_path(int unsigned s);
		int unsigned wq[MAX_NODES];
		bit          inq[MAX_NODES];
		int unsigned rcnt[MAX_NODES];
		int unsigned qh, qn, u, e, v;
		longint      nd;
		for (int i = 0; i < MAX_NODES; i++) begin
			s_seen[i] = 1'b0;
			inq[i] = 1'b0;
			s_pred[i] = NO_EDGE;
			rcnt[i] = 0;
		end
		s_seen[s] = 1'b1;
		s_dist[s] = 0;
		wq[0] = s;
		inq[s] = 1'b1;
		qh = 0;
		qn = 1;
		while (qn > 0) begin
			u = wq[qh];
			qh = (qh + 1) % MAX_NODES;
			qn--;
			inq[u] = 1'b0;
			e = g_head[u];
			while (e < MAX_EDGES && e < g_count) begin
				v = g_to[e];
				if (v < MAX_NODES && g_res[e] != 0) begin
					nd = sat48(s_dist[u] + longint'(g_wt[e]));
					if (!s_seen[v] || nd > s_dist[v]) begin
						s_seen[v] = 1'b1;
						s_dist[v] = nd;
						s_pred[v] = e;
						rcnt[v]++;
						if (rcnt[v] > MAX_NODES) return 1'b0;
						if (!inq[v]) begin
							inq[v] = 1'b1;
							wq[(qh + qn) % MAX_NODES] = v;
							qn++;
						end
					end
				end
				e = g_next[e];
			end
		end
		return 1'b1;
	endfunction

	function automatic totals_t solve_flow();
		totals_t     t;
		int unsigned flow, amt, node, steps, e;
		longint      cost;
		bit          ok;
		flow = 0;
		cost = 0;
		if (src_sel != snk_sel) begin
			forever begin
				amt = PUSH_CAP;
				node = snk_sel;
				steps = 0;
				ok = 1'b1;
				if (!longest_path(src_sel)) break;
				if (!s_seen[snk_sel] || s_dist[snk_sel] < 0) break;
				while (node != src_sel) begin
					e = s_pred[node];
					if (steps >= MAX_NODES || e >= MAX_EDGES || e >= g_count) begin
						ok = 1'b0;
						break;
					end
					steps++;
					if (g_res[e] < amt) amt = g_res[e];
					node = g_from[e];
				end
				if (!ok || amt == 0) break;
				node = snk_sel;
				while (node != src_sel) begin
					e = s_pred[node];
					g_res[e] -= amt;
					if ((e ^ 1) < g_count) g_res[e ^ 1] += amt;
					node = g_from[e];
				end
				flow = (flow + amt > FLOW_SAT) ? FLOW_SAT : flow + amt;
				cost = sat48(cost + s_dist[snk_sel] * longint'(amt));
			end
		end
		t.flow = flow[FLOW_W-1:0];
		t.cost = cost[DIST_W-1:0];
		t.status = g_full;
		return t;
	endfunction

	// apply one accepted word to the predictor; 1 when it yields totals
	function automatic bit predict_word(stim_row_t r, output totals_t t);
		t = '0;
		case (r.func)
			FUNC_CLEAR: graph_clear();
			FUNC_ADD: graph_add(r.from_node, r.to_node, r.capacity, int'(r.edge_cost));
			FUNC_RUN: begin
				t = solve_flow();
				return 1'b1;
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	task automatic send_word(stim_row_t r);
		totals_t t;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.func      <= r.func;
		item_ch.from_node <= r.from_node;
		item_ch.to_node   <= r.to_node;
		item_ch.capacity  <= r.capacity;
		item_ch.edge_cost <= r.edge_cost;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		if (predict_word(r, t)) pending_totals.push_back(r.typed ? r.want : t);
		if (r.func != FUNC_BAD) items_sent++;
	endtask

	// sender holds off until every run has reported, then lets the block settle
	task automatic settle();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_totals.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [NODE_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
		if (idx == CFG_SOURCE) src_sel = val;
		else snk_sel = val;
	endtask

	task automatic set_ends(int unsigned s, int unsigned k);
		settle();
		write_reg(CFG_SOURCE, s[NODE_W-1:0]);
		write_reg(CFG_SINK, k[NODE_W-1:0]);
	endtask

	function automatic stim_row_t word(logic [1:0] f, int unsigned a = 0, int unsigned b = 0,
			int unsigned cap = 0, int w = 0);
		stim_row_t r;
		r = '0;
		r.func = f;
		r.from_node = a[NODE_W-1:0];
		r.to_node = b[NODE_W-1:0];
		r.capacity = cap[CAP_W-1:0];
		r.edge_cost = w;
		return r;
	endfunction

	function automatic stim_row_t zero_run();
		stim_row_t r;
		r = word(FUNC_RUN);
		r.typed = 1'b1;
		return r;
	endfunction

	function automatic int pick_cost();
		case ($urandom_range(0, 7))
			0: return int'($urandom);
			1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default: return (int'($urandom_range(0, 80)) - 40) * 65536 + int'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic int unsigned pick_cap();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 65535;
			2: return $urandom_range(0, 65535);
			default: return $urandom_range(1, 30000);
		endcase
	endfunction

	// result side: bursty ready and in-order compare
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		totals_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (quiet) begin
				res_ch.ready <= 1'b1;
			end else if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else if ($urandom_range(0, 5) == 0) begin
				res_ch.ready <= 1'b0;
				stall_left <= $urandom_range(0, 17);
			end else begin
				res_ch.ready <= 1'b1;
			end
			if (res_ch.valid && res_ch.ready) begin
				if (pending_totals.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected totals: flow %0d cost %0d status %0d",
							res_ch.total_flow, res_ch.total_cost, res_ch.status);
				end else begin
					want = pending_totals.pop_front();
					if (res_ch.total_flow !== want.flow || res_ch.total_cost !== want.cost
							|| res_ch.status !== want.status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("totals differ: flow %0d/%0d cost %0d/%0d status %0d/%0d",
								want.flow, res_ch.total_flow, want.cost, res_ch.total_cost,
								want.status, res_ch.status);
					end
				end
			end
		end
	end

	// watchdog on cycles with no word moving anywhere
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	stim_row_t dir_rows[20];

	initial begin
		int unsigned n, m, ids[8];
		stim_row_t   r;
		item_ch.valid     <= 1'b0;
		item_ch.func      <= FUNC_CLEAR;
		item_ch.from_node <= '0;
		item_ch.to_node   <= '0;
		item_ch.capacity  <= '0;
		item_ch.edge_cost <= '0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.index      <= CFG_SOURCE;
		cfg_ch.data       <= '0;
		quiet = 1'b0;
		items_sent = 0;
		graph_clear();
		src_sel = 0;
		snk_sel = SINK_RESET;

		dir_rows[0]  = zero_run();
		dir_rows[1]  = word(FUNC_ADD, 0, 127, 65535, 32'sh7FFF_FFFF);
		dir_rows[2]  = word(FUNC_RUN);
		dir_rows[3]  = word(FUNC_ADD, 0, 127, 1, 32'sh8000_0000);  // twin cost saturates
		dir_rows[4]  = word(FUNC_RUN);
		dir_rows[5]  = word(FUNC_BAD, 127, 127, 65535, -1);
		dir_rows[6]  = word(FUNC_CLEAR);
		dir_rows[7]  = zero_run();
		dir_rows[8]  = word(FUNC_ADD, 0, 1, 0, 5);
		dir_rows[9]  = word(FUNC_ADD, 0, 1, 20000, 65536);
		dir_rows[10] = word(FUNC_ADD, 1, 127, 30000, -65536);
		dir_rows[11] = word(FUNC_ADD, 1, 127, 3, 131072);
		dir_rows[12] = word(FUNC_RUN);
		// positive cycle reachable from the source
		dir_rows[13] = word(FUNC_ADD, 2, 3, 5, 1);
		dir_rows[14] = word(FUNC_ADD, 3, 2, 5, 1);
		dir_rows[15] = word(FUNC_ADD, 0, 2, 5, 0);
		dir_rows[16] = word(FUNC_RUN);
		dir_rows[17] = word(FUNC_CLEAR);
		dir_rows[18] = word(FUNC_ADD, 127, 0, 7, -7);
		dir_rows[19] = zero_run();  // sink unreachable

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) send_word(dir_rows[i]);

		// source equals sink, then reversed extremes
		set_ends(5, 5);
		send_word(word(FUNC_ADD, 5, 5, 9, 3));
		send_word(word(FUNC_RUN));
		set_ends(127, 0);
		send_word(word(FUNC_CLEAR));
		send_word(word(FUNC_ADD, 127, 0, 12345, 32'sh0001_0000));
		send_word(word(FUNC_RUN));

		// fill the edge store past its end
		set_ends(0, 1);
		send_word(word(FUNC_CLEAR));
		for (int i = 0; i <= MAX_EDGES / 2; i++)
			send_word(word(FUNC_ADD, 5, 6, $urandom_range(0, 65535), pick_cost()));
		send_word(word(FUNC_RUN));
		send_word(word(FUNC_CLEAR));
		send_word(word(FUNC_RUN));

		while (items_sent < ITEM_GOAL) begin
			if (items_sent > QUIET_FROM) quiet = 1'b1;
			n = $urandom_range(2, 8);
			foreach (ids[i]) ids[i] = $urandom_range(0, 127);
			if ($urandom_range(0, 3) == 0) set_ends(ids[0], ids[n-1]);
			else if ($urandom_range(0, 5) == 0) set_ends($urandom_range(0, 1) * 127, ids[1]);
			if ($urandom_range(0, 3) != 0) send_word(word(FUNC_CLEAR));
			m = $urandom_range(1, 12);
			for (int i = 0; i < m; i++) begin
				if ($urandom_range(0, 7) == 0) begin
					r = word(2'($urandom_range(0, 3)), $urandom_range(0, 127),
						$urandom_range(0, 127), $urandom_range(0, 65535), int'($urandom));
					if (r.func == FUNC_CLEAR && $urandom_range(0, 1)) r.func = FUNC_ADD;
				end else begin
					r = word(FUNC_ADD, ids[$urandom_range(0, n - 1)], ids[$urandom_range(0, n - 1)],
						pick_cap(), pick_cost());
				end
				send_word(r);
				if ($urandom_range(0, 9) == 0) send_word(word(FUNC_RUN));
			end
			send_word(word(FUNC_RUN));
			if ($urandom_range(0, 2) == 0) send_word(word(FUNC_RUN));
		end

		settle();
		if (mismatches == 0 && pending_totals.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
`default_nettype wire
